/* src/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the streaming huffman byte decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int Nodes      = 512;
    localparam int StackDepth = 256;
    localparam int NodeW      = $clog2(Nodes);
    localparam int SpW        = $clog2(StackDepth);
    localparam int QDepth     = 4;
    localparam int QW         = $clog2(QDepth);

    localparam logic [2:0] StSymbol = 3'd0;
    localparam logic [2:0] StDone   = 3'd1;
    localparam logic [2:0] StHeader = 3'd2;
    localparam logic [2:0] StEnd    = 3'd3;
    localparam logic [2:0] StOvf    = 3'd4;

    localparam logic OpData = 1'b0;
    localparam logic OpEnd  = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [63:0] repeat_count;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       is_leaf;
        logic [7:0] value;
        logic [NodeW-1:0] right;
    } t_node;

    typedef enum logic [2:0] {
        PH_TREE, PH_SIZE, PH_PAYLOAD, PH_DONE, PH_FAILED
    } t_phase;

    typedef enum logic [2:0] {
        BK_IDLE, BK_READ, BK_WALK, BK_EMIT, BK_FLUSH
    } t_bk_state;

endpackage

/* src/hsd_front.sv */
// ----------------------------------------------------------------------------
// hsd_front
// Input queue: takes items and holds them for the decoding back end.
// ----------------------------------------------------------------------------
module hsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hsd_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output hsd_pkg::t_in_item o_item,
    input  logic              i_take
);
    hsd_pkg::t_in_item r_mem [hsd_pkg::QDepth];
    logic [hsd_pkg::QW-1:0] r_wp, r_rp;
    logic [hsd_pkg::QW:0]   r_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == (hsd_pkg::QW+1)'(hsd_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (hsd_pkg::QW+1)'(wr) - (hsd_pkg::QW+1)'(rd);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (hsd_pkg::QW+1)'(hsd_pkg::QDepth))
        else $error("queue count out of range");
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt >= (hsd_pkg::QW+1)'(hsd_pkg::QDepth - 1))
        else $error("count dropped too fast");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |=> r_cnt <= 1)
        else $error("count grew too fast");
endmodule

/* src/hsd_back.sv */
// ----------------------------------------------------------------------------
// hsd_back
// Decoding back end: header parse, count capture and bit-serial tree walk.
// ----------------------------------------------------------------------------
module hsd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hsd_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_out_valid,
    output hsd_pkg::t_out_item o_out,
    input  logic               i_out_ready
);
    localparam int NW = hsd_pkg::NodeW;
    localparam int SW = hsd_pkg::SpW;

    hsd_pkg::t_node   r_nodes [hsd_pkg::Nodes];
    logic [NW-1:0]    r_stack [hsd_pkg::StackDepth];

    hsd_pkg::t_phase    r_phase, n_phase;
    hsd_pkg::t_bk_state r_st, n_st;
    logic [SW:0]   r_sp, n_sp;
    logic [NW:0]   r_ncnt, n_ncnt;
    logic          r_expv, n_expv;
    logic [63:0]   r_total, n_total;
    logic [3:0]    r_sbi, n_sbi;
    logic [63:0]   r_written, n_written;
    logic [NW-1:0] r_cur, n_cur;
    logic [7:0]    r_byte, n_byte;
    logic [3:0]    r_bit, n_bit;
    hsd_pkg::t_out_item r_out, n_out;
    logic          r_ov, n_ov;
    hsd_pkg::t_out_item r_hold, n_hold;
    logic          r_hv, n_hv;
    logic          r_rd_stack, n_rd_stack;

    hsd_pkg::t_node r_rnode;
    logic [NW-1:0]  r_raddr, n_raddr;
    logic [NW-1:0]  r_sdata;

    logic           nw_en, nw_full, nv_en, nr_en;
    logic [NW-1:0]  nw_addr, nr_addr;
    hsd_pkg::t_node nw_data;
    logic [7:0]     nv_data;
    logic [NW-1:0]  nr_data;
    logic           s_push;
    logic [SW-1:0]  s_addr;
    logic [NW-1:0]  s_data;
    logic           s_rd;
    logic [SW-1:0]  s_raddr;
    logic           walk_bit;
    logic [NW:0]    nxt_w;
    logic [NW-1:0]  nxt;

    assign o_out_valid = r_ov;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (nw_en) r_nodes[nw_addr] <= nw_data;
        if (nv_en) r_nodes[nw_addr].value <= nv_data;
        if (nr_en) r_nodes[nr_addr].right <= nr_data;
        r_rnode <= r_nodes[n_raddr];
        if (s_push) r_stack[s_addr] <= s_data;
        if (s_rd) r_sdata <= r_stack[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hsd_pkg::PH_TREE;
            r_st <= hsd_pkg::BK_IDLE;
            r_sp <= '0;
            r_ncnt <= '0;
            r_expv <= 1'b0;
            r_total <= '0;
            r_sbi <= '0;
            r_written <= '0;
            r_cur <= '0;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
            r_rd_stack <= 1'b0;
            r_raddr <= '0;
        end else begin
            r_phase <= n_phase;
            r_st <= n_st;
            r_sp <= n_sp;
            r_ncnt <= n_ncnt;
            r_expv <= n_expv;
            r_total <= n_total;
            r_sbi <= n_sbi;
            r_written <= n_written;
            r_cur <= n_cur;
            r_ov <= n_ov;
            r_hv <= n_hv;
            r_rd_stack <= n_rd_stack;
            r_raddr <= n_raddr;
        end
        r_byte <= n_byte;
        r_bit <= n_bit;
        r_out <= n_out;
        r_hold <= n_hold;
    end

    assign walk_bit = r_byte[3'(7 - r_bit[2:0])];
    assign nxt_w = walk_bit ? {1'b0, r_rnode.right} : {1'b0, r_cur} + 1'b1;
    assign nxt = (nxt_w >= (NW+1)'(hsd_pkg::Nodes)) ? '0 : nxt_w[NW-1:0];

    always_comb begin
        n_phase = r_phase;  n_st = r_st;  n_sp = r_sp;  n_ncnt = r_ncnt;
        n_expv = r_expv;  n_total = r_total;  n_sbi = r_sbi;
        n_written = r_written;  n_cur = r_cur;  n_byte = r_byte;  n_bit = r_bit;
        n_out = r_out;  n_ov = r_ov;  n_rd_stack = 1'b0;  n_raddr = r_raddr;
        n_hold = r_hold;  n_hv = r_hv;
        o_take = 1'b0;
        nw_en = 1'b0;  nv_en = 1'b0;  nr_en = 1'b0;
        nw_addr = r_ncnt[NW-1:0];  nw_data = '0;  nv_data = i_item.in_byte;
        nr_addr = r_sdata;  nr_data = r_ncnt[NW-1:0];
        s_push = 1'b0;  s_addr = r_sp[SW-1:0];  s_data = r_ncnt[NW-1:0];
        s_rd = 1'b0;  s_raddr = SW'(r_sp - 1'b1);
        nw_full = (r_ncnt >= (NW+1)'(hsd_pkg::Nodes));

        if (r_ov && i_out_ready) n_ov = 1'b0;
        // finish a pending right-child link from the stack read
        if (r_rd_stack) nr_en = 1'b1;

        case (r_st)
            hsd_pkg::BK_IDLE: begin
                if (i_valid && !r_ov && !r_rd_stack) begin
                    o_take = 1'b1;
                    case (r_phase)
                        hsd_pkg::PH_TREE: begin
                            if (i_item.opcode == hsd_pkg::OpEnd) begin
                                n_out = '{8'd0, 64'd0, hsd_pkg::StHeader, 1'b1};
                                n_ov = 1'b1;  n_phase = hsd_pkg::PH_FAILED;
                            end else if (r_expv) begin
                                if (r_ncnt != '0) begin
                                    nv_en = 1'b1;
                                    nw_addr = NW'(r_ncnt - 1'b1);
                                end
                                n_expv = 1'b0;
                                if (r_sp == '0) begin
                                    n_phase = hsd_pkg::PH_SIZE;
                                end else begin
                                    n_sp = r_sp - 1'b1;
                                    s_rd = 1'b1;
                                    n_rd_stack = 1'b1;
                                end
                            end else if (nw_full) begin
                                n_out = '{8'd0, 64'd0, hsd_pkg::StOvf, 1'b1};
                                n_ov = 1'b1;  n_phase = hsd_pkg::PH_FAILED;
                            end else begin
                                nw_en = 1'b1;
                                nw_data = '{i_item.in_byte == 8'd1, 8'd0, '0};
                                n_ncnt = r_ncnt + 1'b1;
                                if (i_item.in_byte == 8'd1) begin
                                    n_expv = 1'b1;
                                end else if (r_sp >= (SW+1)'(hsd_pkg::StackDepth)) begin
                                    n_out = '{8'd0, 64'd0, hsd_pkg::StOvf, 1'b1};
                                    n_ov = 1'b1;  n_phase = hsd_pkg::PH_FAILED;
                                end else begin
                                    s_push = 1'b1;
                                    n_sp = r_sp + 1'b1;
                                end
                            end
                        end
                        hsd_pkg::PH_SIZE: begin
                            if (i_item.opcode == hsd_pkg::OpEnd) begin
                                n_out = '{8'd0, 64'd0, hsd_pkg::StHeader, 1'b1};
                                n_ov = 1'b1;  n_phase = hsd_pkg::PH_FAILED;
                            end else begin
                                n_total = r_total
                                    | (64'(i_item.in_byte) << {r_sbi[2:0], 3'b000});
                                n_sbi = r_sbi + 1'b1;
                                if (r_sbi == 4'd7) begin
                                    n_raddr = '0;
                                    n_st = hsd_pkg::BK_READ;
                                    n_bit = 4'd8;
                                end
                            end
                        end
                        hsd_pkg::PH_PAYLOAD: begin
                            if (i_item.opcode == hsd_pkg::OpEnd) begin
                                n_out = '{8'd0, 64'd0, hsd_pkg::StEnd, 1'b1};
                                n_ov = 1'b1;  n_phase = hsd_pkg::PH_FAILED;
                            end else begin
                                n_byte = i_item.in_byte;
                                n_bit = '0;
                                n_raddr = r_cur;
                                n_st = hsd_pkg::BK_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hsd_pkg::BK_READ: begin
                // node read address settles, data arrives next cycle
                n_st = hsd_pkg::BK_WALK;
            end
            hsd_pkg::BK_WALK: begin
                if (r_bit == 4'd8) begin
                    // root check after the count
                    if (r_rnode.is_leaf) begin
                        n_out = '{r_rnode.value, n_total, hsd_pkg::StDone, 1'b1};
                        n_ov = 1'b1;  n_phase = hsd_pkg::PH_DONE;
                    end else if (r_total == 64'd0) begin
                        n_out = '{8'd0, 64'd0, hsd_pkg::StDone, 1'b1};
                        n_ov = 1'b1;  n_phase = hsd_pkg::PH_DONE;
                    end else begin
                        n_phase = hsd_pkg::PH_PAYLOAD;
                        n_cur = '0;
                    end
                    n_st = hsd_pkg::BK_IDLE;
                end else begin
                    n_raddr = nxt;
                    n_cur = nxt;
                    n_st = hsd_pkg::BK_EMIT;
                end
            end
            hsd_pkg::BK_EMIT: begin
                // r_rnode now holds the child node; a symbol is held back until
                // it is known whether it is the last of the item
                if (!r_ov) begin
                    n_bit = r_bit + 1'b1;
                    n_st = hsd_pkg::BK_READ;
                    n_raddr = r_cur;
                    if (r_rnode.is_leaf) begin
                        n_written = r_written + 1'b1;
                        n_cur = '0;
                        n_raddr = '0;
                        if (r_hv) begin
                            n_out = r_hold;
                            n_ov = 1'b1;
                        end
                        n_hv = 1'b1;
                        if (n_written >= r_total) begin
                            n_hold = '{r_rnode.value, 64'd1, hsd_pkg::StDone, 1'b0};
                            n_phase = hsd_pkg::PH_DONE;
                            n_st = hsd_pkg::BK_FLUSH;
                        end else begin
                            n_hold = '{r_rnode.value, 64'd1, hsd_pkg::StSymbol, 1'b0};
                        end
                    end
                    if (r_bit == 4'd7 && n_st == hsd_pkg::BK_READ) begin
                        n_st = n_hv ? hsd_pkg::BK_FLUSH : hsd_pkg::BK_IDLE;
                    end
                end
            end
            hsd_pkg::BK_FLUSH: begin
                if (!r_ov) begin
                    n_out = r_hold;
                    n_out.last = 1'b1;
                    n_ov = r_hv;
                    n_hv = 1'b0;
                    n_st = hsd_pkg::BK_IDLE;
                end
            end
            default: n_st = hsd_pkg::BK_IDLE;
        endcase
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (SW+1)'(hsd_pkg::StackDepth))
        else $error("stack pointer beyond depth");
    a_ncnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= (NW+1)'(hsd_pkg::Nodes))
        else $error("node count beyond table");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_st == hsd_pkg::BK_IDLE && !r_ov))
        else $error("item taken while busy");
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hsd_pkg::PH_DONE && r_st == hsd_pkg::BK_IDLE && !r_ov)
        |=> !r_ov)
        else $error("result after finish");
endmodule

/* src/huffman_stream_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Streaming huffman decoder for byte symbols with tree header and count.
// ----------------------------------------------------------------------------
// channel | ports                       | handshake
// in      | i_push, o_full, i_in_item   | push && !full
// out     | o_empty, i_pop, o_out_item  | pop && !empty
// header and count items are taken in the idle state; when a leaf closes a
// subtree, a right-child link is also written from a stack read, and the last
// count byte adds a root check (node read, walk). a payload item is taken,
// then each bit passes node read, walk and step, then the held symbol is
// flushed; the walk stalls while a result waits to be popped.
// reset is synchronous and active low; no clearing pass is needed.
// a four-item input queue lets the producer run ahead of the tree walk.
// ----------------------------------------------------------------------------
module huffman_stream_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  hsd_pkg::t_in_item  i_in_item,
    output logic               o_empty,
    input  logic               i_pop,
    output hsd_pkg::t_out_item o_out_item
);
    logic q_valid, q_take, out_valid;
    hsd_pkg::t_in_item q_item;

    hsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_in_item),
        .o_full(o_full), .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    hsd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_take(q_take), .o_out_valid(out_valid), .o_out(o_out_item),
        .i_out_ready(i_pop)
    );

    assign o_empty = !out_valid;
endmodule
